@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks shared by the haversine distance RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on clk_i; hold off while rst_ni is low.
`define HGCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that pre implies post on the same clock edge.
`define HGCD_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

@@ rtl/core/hgcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hgcd_pkg
// Widths, angle constants and CORDIC tables for the haversine distance core.
// ----------------------------------------------------------------------------
package hgcd_pkg;

  localparam int unsigned AngleFracBits = 30;
  localparam int unsigned CordicSteps   = 32;
  localparam int unsigned SqrtSteps     = 32;

  localparam int unsigned LatW    = 28;
  localparam int unsigned LonW    = 29;
  localparam int unsigned RadiusW = 33;
  localparam int unsigned DistW   = 35;

  localparam int unsigned MudegW = 30;                  // reduced angle magnitudes
  localparam int unsigned RedW   = 28;                  // folded angle, at most 180e6
  localparam int unsigned UnitW  = AngleFracBits + 1;   // values in [0, 1]
  localparam int unsigned AngW   = AngleFracBits + 2;   // angles in [0, pi]
  localparam int unsigned RotW   = AngleFracBits + 4;   // rotation x, y, z
  localparam int unsigned RootW  = SqrtSteps;
  localparam int unsigned RemW   = 2 * SqrtSteps - 1;
  localparam int unsigned VecW   = SqrtSteps + 4;
  localparam int unsigned RadLoW = 17;
  localparam int unsigned RadHiW = RadiusW - RadLoW;

  localparam logic [63:0] PiQ60          = 64'h3243F6A8885A308D;
  localparam logic [63:0] RadPerMudegQ60 = (PiQ60 + 64'd90000000) / 64'd180000000;

  localparam logic [MudegW-1:0] FullTurn    = MudegW'(360000000);
  localparam logic [MudegW-1:0] HalfTurn    = MudegW'(180000000);
  localparam logic [MudegW-1:0] QuarterTurn = MudegW'(90000000);

  localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(64'd6372797561);

  localparam logic [UnitW-1:0] OneQ = UnitW'(64'd1 << AngleFracBits);
  localparam logic [AngW-1:0]  PiQ  =
    AngW'((PiQ60 + (64'd1 << (59 - AngleFracBits))) >> (60 - AngleFracBits));

  // Shift-subtract long division, elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    bt  = 64'd1 << 62;
    rem = v;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // atan(2^-i) by its series in Q62, rounded to the angle format.
  function automatic logic [63:0] atan_entry(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned e;
    logic        done;
    acc  = '0;
    done = 1'b0;
    if (i == 0) begin
      acc = PiQ60;
    end else begin
      for (int unsigned k = 0; k < 32; k++) begin
        if (!done) begin
          e = i * (2 * k + 1);
          if (e > 62) begin
            done = 1'b1;
          end else begin
            term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
            if (k[0]) acc = acc - term;
            else      acc = acc + term;
          end
        end
      end
    end
    return (acc + (64'd1 << (61 - AngleFracBits))) >> (62 - AngleFracBits);
  endfunction

  // Inverse CORDIC gain, rounded half up.
  function automatic logic [63:0] gain_entry();
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    p = 64'd1 << 60;
    for (int unsigned i = 0; i < CordicSteps; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    d = isqrt64(p);
    q = udiv64(64'd1 << (AngleFracBits + 30), d);
    r = (64'd1 << (AngleFracBits + 30)) - q * d;
    if ((r << 1) >= d) q = q + 64'd1;
    return q;
  endfunction

  localparam logic signed [RotW-1:0] GainQ = RotW'(gain_entry());

endpackage

@@ rtl/core/haversine_great_circle_distance.sv @@
// ----------------------------------------------------------------------------
// haversine_great_circle_distance
// Fully pipelined great-circle distance between two points in microdegrees.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  request   | start, busy (out), first/second lat/lon   | in
//  result    | result_valid_o, distance_mm_o             | out
//  config    | cfg_we_i, cfg_wdata_i (earth_radius_mm)   | in
//
//  A request is taken at every edge where start is high; busy is always low,
//  so a new pair enters every cycle. Its result strobes on result_valid_o
//  for one cycle; the pipeline depth is set by the 32-step rotation
//  CORDIC, the 32-digit square roots and the 32-step vectoring CORDIC,
//  each one step per register stage.
//  Reset clears the valid line and loads the default radius; the datapath
//  itself carries no reset. The receiver cannot stall, so nothing ever holds.
//
//  Flow: difference and fold angles -> scale to radians -> rotation CORDIC
//  (sin of half differences, cos of latitudes) -> form a -> sqrt(a),
//  sqrt(1-a) -> vectoring CORDIC for the central angle -> scale by radius.
//
`include "assert_macros.svh"

module haversine_great_circle_distance
  import hgcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [LatW-1:0] first_lat_i,
  input  logic signed [LonW-1:0] first_lon_i,
  input  logic signed [LatW-1:0] second_lat_i,
  input  logic signed [LonW-1:0] second_lon_i,
  input  logic                   cfg_we_i,
  input  logic [RadiusW-1:0]     cfg_wdata_i,
  output logic                   result_valid_o,
  output logic [DistW-1:0]       distance_mm_o
);

  // Stage numbering of the valid line (index = stage - 1).
  localparam int unsigned Latency    = 11 + 2 * CordicSteps + SqrtSteps;
  localparam int unsigned ClampIdx   = Latency - 3;
  localparam int unsigned NumLanes   = 4;  // half dlat, half dlon, lat1, lat2

  logic [Latency-1:0] vld_q;
  logic [RadiusW-1:0] radius_q;

  assign busy = 1'b0;

  // Control: radius register and valid line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
      vld_q    <= '0;
    end else begin
      if (cfg_we_i) radius_q <= cfg_wdata_i;
      vld_q <= {vld_q[Latency-2:0], start};
    end
  end

  // Stage 1: capture the request.
  logic signed [LatW-1:0] lat1_q, lat2_q;
  logic signed [LonW-1:0] lon1_q, lon2_q;

  always_ff @(posedge clk_i) begin
    lat1_q <= first_lat_i;
    lon1_q <= first_lon_i;
    lat2_q <= second_lat_i;
    lon2_q <= second_lon_i;
  end

  // Stage 2: differences, modulo one turn, fold into [0, 180] degrees; latitudes into [0, 90].
  logic signed [LatW:0]   dlat;
  logic signed [LonW:0]   dlon;
  logic [MudegW-1:0]      mlat, mlon, mlon_r, ml1, ml2;
  logic [MudegW-1:0]      fl, fo, f1, f2;
  logic                   n1, n2;
  logic [RedW-1:0]        red_q [NumLanes];
  logic                   neg_red_q;

  always_comb begin
    dlat   = (LatW + 1)'(lat1_q) - (LatW + 1)'(lat2_q);
    dlon   = (LonW + 1)'(lon1_q) - (LonW + 1)'(lon2_q);
    mlat   = MudegW'(dlat[LatW] ? -dlat : dlat);
    mlon   = MudegW'(dlon[LonW] ? -dlon : dlon);
    mlon_r = (mlon >= FullTurn) ? mlon - FullTurn : mlon;
    fl     = (mlat > HalfTurn) ? FullTurn - mlat : mlat;
    fo     = (mlon_r > HalfTurn) ? FullTurn - mlon_r : mlon_r;
    // Widen before negating so the most negative latitude keeps its magnitude.
    ml1    = MudegW'(lat1_q[LatW-1] ? -(LatW + 1)'(lat1_q) : (LatW + 1)'(lat1_q));
    ml2    = MudegW'(lat2_q[LatW-1] ? -(LatW + 1)'(lat2_q) : (LatW + 1)'(lat2_q));
    n1     = ml1 > QuarterTurn;
    n2     = ml2 > QuarterTurn;
    f1     = n1 ? HalfTurn - ml1 : ml1;
    f2     = n2 ? HalfTurn - ml2 : ml2;
  end

  always_ff @(posedge clk_i) begin
    red_q[0]  <= RedW'(fl);
    red_q[1]  <= RedW'(fo);
    red_q[2]  <= RedW'(f1);
    red_q[3]  <= RedW'(f2);
    neg_red_q <= n1 ^ n2;
  end

  // Stage 3: scale microdegrees to radians (Q60 product).
  logic [63:0] rad_prod_q [NumLanes];
  logic        neg_mul_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumLanes; l++) begin
      rad_prod_q[l] <= 64'(red_q[l]) * RadPerMudegQ60;
    end
    neg_mul_q <= neg_red_q;
  end

  // Rotation CORDIC: stage 0 loads, stages 1..CordicSteps iterate.
  logic signed [RotW-1:0] rx_q [CordicSteps+1][NumLanes];
  logic signed [RotW-1:0] ry_q [CordicSteps+1][NumLanes];
  logic signed [RotW-1:0] rz_q [CordicSteps+1][NumLanes];
  logic                   neg_rot_q [CordicSteps+1];

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumLanes; l++) begin
      rx_q[0][l] <= GainQ;
      ry_q[0][l] <= '0;
    end
    // Half angles for the differences, full angles for the latitudes.
    for (int l = 0; l < 2; l++) begin
      rz_q[0][l] <= RotW'((rad_prod_q[l] + (64'd1 << (60 - AngleFracBits)))
                          >> (61 - AngleFracBits));
    end
    for (int l = 2; l < NumLanes; l++) begin
      rz_q[0][l] <= RotW'((rad_prod_q[l] + (64'd1 << (59 - AngleFracBits)))
                          >> (60 - AngleFracBits));
    end
    neg_rot_q[0] <= neg_mul_q;
  end

  for (genvar s = 0; s < CordicSteps; s++) begin : g_rot
    localparam logic signed [RotW-1:0] AtanS = RotW'(atan_entry(s));
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        if (rz_q[s][l] >= 0) begin
          rx_q[s+1][l] <= rx_q[s][l] - (ry_q[s][l] >>> s);
          ry_q[s+1][l] <= ry_q[s][l] + (rx_q[s][l] >>> s);
          rz_q[s+1][l] <= rz_q[s][l] - AtanS;
        end else begin
          rx_q[s+1][l] <= rx_q[s][l] + (ry_q[s][l] >>> s);
          ry_q[s+1][l] <= ry_q[s][l] - (rx_q[s][l] >>> s);
          rz_q[s+1][l] <= rz_q[s][l] + AtanS;
        end
      end
      neg_rot_q[s+1] <= neg_rot_q[s];
    end
  end

  function automatic logic [UnitW-1:0] clamp_unit(input logic signed [RotW-1:0] v);
    logic [UnitW-1:0] r;
    if (v < 0)                          r = '0;
    else if (v > $signed(RotW'(OneQ)))  r = OneQ;
    else                                r = UnitW'(v);
    return r;
  endfunction

  // Round a product of two unit values back to the unit format.
  function automatic logic [UnitW-1:0] mul_unit(input logic [UnitW-1:0] a,
                                                input logic [UnitW-1:0] b);
    logic [2*UnitW-1:0] p;
    p = (2 * UnitW)'(a) * (2 * UnitW)'(b) + (2 * UnitW)'(64'd1 << (AngleFracBits - 1));
    return UnitW'(p >> AngleFracBits);
  endfunction

  // Products: sin^2 of half angles and cos(lat1)*cos(lat2).
  logic [UnitW-1:0] sl_q, so_q, cc_q;
  logic             neg_p1_q;
  logic [UnitW-1:0] s_dl, s_do, c_l1, c_l2;

  always_comb begin
    s_dl = clamp_unit(ry_q[CordicSteps][0]);
    s_do = clamp_unit(ry_q[CordicSteps][1]);
    c_l1 = clamp_unit(rx_q[CordicSteps][2]);
    c_l2 = clamp_unit(rx_q[CordicSteps][3]);
  end

  always_ff @(posedge clk_i) begin
    sl_q     <= mul_unit(s_dl, s_dl);
    so_q     <= mul_unit(s_do, s_do);
    cc_q     <= mul_unit(c_l1, c_l2);
    neg_p1_q <= neg_rot_q[CordicSteps];
  end

  logic [UnitW-1:0] sl2_q, t2_q;
  logic             neg_p2_q;

  always_ff @(posedge clk_i) begin
    sl2_q    <= sl_q;
    t2_q     <= mul_unit(cc_q, so_q);
    neg_p2_q <= neg_p1_q;
  end

  // Form a, clamp to [0, 1], and load both square roots.
  logic signed [UnitW+1:0] a_raw;
  logic [UnitW-1:0]        a_val, b_val;

  always_comb begin
    a_raw = neg_p2_q ? (UnitW + 2)'(sl2_q) - (UnitW + 2)'(t2_q)
                     : (UnitW + 2)'(sl2_q) + (UnitW + 2)'(t2_q);
    if (a_raw < 0)                               a_val = '0;
    else if (a_raw > $signed((UnitW + 2)'(OneQ))) a_val = OneQ;
    else                                          a_val = UnitW'(a_raw);
    b_val = OneQ - a_val;
  end

  // Digit-by-digit square roots, one result bit per stage (lane 0: a, 1: 1-a).
  logic [RemW-1:0]  rem_q  [SqrtSteps+1][2];
  logic [RootW-1:0] root_q [SqrtSteps+1][2];

  always_ff @(posedge clk_i) begin
    rem_q[0][0]  <= RemW'(a_val) << (62 - AngleFracBits);
    rem_q[0][1]  <= RemW'(b_val) << (62 - AngleFracBits);
    root_q[0][0] <= '0;
    root_q[0][1] <= '0;
  end

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
    localparam int unsigned J = SqrtSteps - 1 - s;
    logic [RemW:0] trial [2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = ((RemW + 1)'(root_q[s][l]) << (J + 1)) + ((RemW + 1)'(1) << (2 * J));
      end
    end
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 2; l++) begin
        if ({1'b0, rem_q[s][l]} >= trial[l]) begin
          rem_q[s+1][l]  <= RemW'({1'b0, rem_q[s][l]} - trial[l]);
          root_q[s+1][l] <= root_q[s][l] | (RootW'(1) << J);
        end else begin
          rem_q[s+1][l]  <= rem_q[s][l];
          root_q[s+1][l] <= root_q[s][l];
        end
      end
    end
  end

  // Vectoring CORDIC: atan2(sqrt(a), sqrt(1-a)).
  logic signed [VecW-1:0] vx_q [CordicSteps+1];
  logic signed [VecW-1:0] vy_q [CordicSteps+1];
  logic signed [RotW-1:0] vz_q [CordicSteps+1];

  always_ff @(posedge clk_i) begin
    vx_q[0] <= VecW'(root_q[SqrtSteps][1]);
    vy_q[0] <= VecW'(root_q[SqrtSteps][0]);
    vz_q[0] <= '0;
  end

  for (genvar s = 0; s < CordicSteps; s++) begin : g_vec
    localparam logic signed [RotW-1:0] AtanS = RotW'(atan_entry(s));
    always_ff @(posedge clk_i) begin
      if (vy_q[s] >= 0) begin
        vx_q[s+1] <= vx_q[s] + (vy_q[s] >>> s);
        vy_q[s+1] <= vy_q[s] - (vx_q[s] >>> s);
        vz_q[s+1] <= vz_q[s] + AtanS;
      end else begin
        vx_q[s+1] <= vx_q[s] - (vy_q[s] >>> s);
        vy_q[s+1] <= vy_q[s] + (vx_q[s] >>> s);
        vz_q[s+1] <= vz_q[s] - AtanS;
      end
    end
  end

  // Double the angle and clamp to [0, pi].
  logic signed [RotW:0] ang2;
  logic [AngW-1:0]      ang_q;

  assign ang2 = (RotW + 1)'(vz_q[CordicSteps]) <<< 1;

  always_ff @(posedge clk_i) begin
    if (ang2 < 0)                             ang_q <= '0;
    else if (ang2 > $signed((RotW + 1)'(PiQ))) ang_q <= PiQ;
    else                                       ang_q <= AngW'(ang2);
  end

  // Scale by radius: two partial products, then sum and round.
  logic [AngW+RadLoW-1:0] plo_q;
  logic [AngW+RadHiW-1:0] phi_q;

  always_ff @(posedge clk_i) begin
    plo_q <= (AngW + RadLoW)'(ang_q) * (AngW + RadLoW)'(radius_q[RadLoW-1:0]);
    phi_q <= (AngW + RadHiW)'(ang_q) * (AngW + RadHiW)'(radius_q[RadiusW-1:RadLoW]);
  end

  localparam int unsigned SumW = AngW + RadiusW + 1;
  logic [SumW-1:0] dist_sum;
  logic [DistW-1:0] dist_q;

  assign dist_sum = (SumW'(phi_q) << RadLoW) + SumW'(plo_q)
                  + SumW'(64'd1 << (AngleFracBits - 1));

  always_ff @(posedge clk_i) begin
    dist_q <= DistW'(dist_sum >> AngleFracBits);
  end

  assign result_valid_o = vld_q[Latency-1];
  assign distance_mm_o  = dist_q;

  // Every result traces back to a request exactly one latency earlier.
  `HGCD_IMPLIES(a_result_has_request, result_valid_o, $past(start, Latency), "result without request")
  // The clamped central angle never exceeds pi.
  `HGCD_IMPLIES(a_angle_in_range, vld_q[ClampIdx], ang_q <= PiQ, "central angle above pi")
  // Busy never rises; a request can enter every cycle.
  `HGCD_ASSERT(a_busy_low, !busy, "busy raised")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the haversine distance core against a fixed-point distance predictor
// over directed coordinate pairs, random pairs and several earth radii.
// ----------------------------------------------------------------------------
module tb_top;
  import hgcd_pkg::*;

  // Fixed-point constants of the distance arithmetic, rebuilt here.
  localparam int          FracBits   = 30;
  localparam int          Steps      = 32;
  localparam logic [63:0] PiQ60Tb    = 64'h3243F6A8885A308D;
  localparam logic [63:0] MudegToRad = (PiQ60Tb + 64'd90000000) / 64'd180000000;
  localparam longint      OneQTb     = longint'(1) << FracBits;
  localparam logic [34:0] DistMask   = '1;
  localparam int          Latency    = 107;
  localparam int          DrainWait  = Latency + 20;
  localparam int          CycleLimit = 400000;
  localparam int          RandItems  = 600;

  typedef struct {
    logic signed [LatW-1:0] lat1;
    logic signed [LonW-1:0] lon1;
    logic signed [LatW-1:0] lat2;
    logic signed [LonW-1:0] lon2;
  } point_pair_t;

  typedef struct {
    point_pair_t pair;
    logic [DistW-1:0] zero_radius_dist;   // typed value, valid when radius is 0
  } pair_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic signed [LatW-1:0] first_lat_i;
  logic signed [LonW-1:0] first_lon_i;
  logic signed [LatW-1:0] second_lat_i;
  logic signed [LonW-1:0] second_lon_i;
  logic                   cfg_we_i;
  logic [RadiusW-1:0]     cfg_wdata_i;
  logic                   result_valid_o;
  logic [DistW-1:0]       distance_mm_o;

  haversine_great_circle_distance dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .first_lat_i    (first_lat_i),
    .first_lon_i    (first_lon_i),
    .second_lat_i   (second_lat_i),
    .second_lon_i   (second_lon_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .distance_mm_o  (distance_mm_o)
  );

  // Predictor state: arctangent table, CORDIC gain, pi and the live radius.
  longint             atan_tab [Steps];
  longint             cordic_gain;
  longint             pi_angle;
  logic [RadiusW-1:0] radius_mm;

  logic [DistW-1:0] pending_dist [$];
  int               mismatches;
  int               cycles;
  int               idle_pct;

  // ---------------------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = '0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // round(a*b / 2^sh), kept to 64 bits
  function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    return 64'(p >> sh);
  endfunction

  function automatic void build_angle_tables();
    logic [63:0] acc;
    logic [63:0] prod;
    logic [63:0] root;
    logic [127:0] num;
    int unsigned e;
    prod = 64'd1 << 60;
    for (int i = 0; i < Steps; i++) begin
      acc = '0;
      if (i == 0) begin
        acc = PiQ60Tb;
      end else begin
        // atan(2^-i) series, stop once the term drops below Q62
        for (int k = 0; k < 64; k++) begin
          e = i * (2 * k + 1);
          if (e > 62) break;
          if (k % 2 == 1) acc = acc - (64'd1 << (62 - e)) / 64'(2 * k + 1);
          else            acc = acc + (64'd1 << (62 - e)) / 64'(2 * k + 1);
        end
      end
      atan_tab[i] = longint'((acc + (64'd1 << (61 - FracBits))) >> (62 - FracBits));
      if (2 * i < 64) prod = prod + (prod >> (2 * i));
    end
    root = int_sqrt(prod);
    // round(2^(F+30) / root)
    num = (128'd1 << (FracBits + 31)) + {64'd0, root};
    cordic_gain = longint'(num / ({64'd0, root} << 1));
    pi_angle = longint'((PiQ60Tb + (64'd1 << (59 - FracBits))) >> (60 - FracBits));
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v < 0) return 0;
    if (v > OneQTb) return OneQTb;
    return v;
  endfunction

  // Rotation CORDIC: cos and sin of z, clamped to [0, 1]
  function automatic void rotate_angle(input longint z, output longint c, output longint s);
    longint x;
    longint y;
    longint nx;
    x = cordic_gain;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end
      x = nx;
    end
    c = clamp_unit(x);
    s = clamp_unit(y);
  endfunction

  // Vectoring CORDIC: atan2(y, x) for nonnegative operands
  function automatic longint vector_atan(input longint y, input longint x);
    longint z;
    longint nx;
    z = 0;
    for (int i = 0; i < Steps; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end
      x = nx;
    end
    return z;
  endfunction

  // Fold a microdegree angle into [0, 180] degrees
  function automatic logic [63:0] fold_mudeg(input longint d);
    logic [63:0] m;
    m = 64'(d < 0 ? -d : d) % 64'd360000000;
    if (m > 64'd180000000) m = 64'd360000000 - m;
    return m;
  endfunction

  function automatic longint half_sin_sq(input longint d);
    logic [63:0] m;
    longint c;
    longint s;
    m = fold_mudeg(d);
    rotate_angle(longint'((m * MudegToRad + (64'd1 << (60 - FracBits))) >> (61 - FracBits)),
                 c, s);
    return longint'(mul_round(64'(s), 64'(s), FracBits));
  endfunction

  function automatic longint lat_cosine(input longint lat, output bit neg);
    logic [63:0] m;
    longint c;
    longint s;
    m   = fold_mudeg(lat);
    neg = 1'b0;
    // reflect latitudes beyond a quarter turn; cosine turns negative
    if (m > 64'd90000000) begin
      m   = 64'd180000000 - m;
      neg = 1'b1;
    end
    rotate_angle(longint'((m * MudegToRad + (64'd1 << (59 - FracBits))) >> (60 - FracBits)),
                 c, s);
    return c;
  endfunction

  function automatic logic [DistW-1:0] great_circle_mm(input point_pair_t p,
                                                       input logic [RadiusW-1:0] r);
    longint sl;
    longint so;
    longint c1;
    longint c2;
    longint t2;
    longint hav;
    longint ang;
    bit     n1;
    bit     n2;
    logic [63:0] ry;
    logic [63:0] rx;
    sl  = half_sin_sq(longint'(p.lat1) - longint'(p.lat2));
    so  = half_sin_sq(longint'(p.lon1) - longint'(p.lon2));
    c1  = lat_cosine(longint'(p.lat1), n1);
    c2  = lat_cosine(longint'(p.lat2), n2);
    t2  = longint'(mul_round(mul_round(64'(c1), 64'(c2), FracBits), 64'(so), FracBits));
    hav = clamp_unit((n1 != n2) ? sl - t2 : sl + t2);
    ry  = int_sqrt(64'(hav) << (62 - FracBits));
    rx  = int_sqrt(64'(OneQTb - hav) << (62 - FracBits));
    ang = 2 * vector_atan(longint'(ry), longint'(rx));
    // hold the central angle within [0, pi]
    if (ang < 0) ang = 0;
    if (ang > pi_angle) ang = pi_angle;
    return DistW'(mul_round(64'(ang), 64'(r), FracBits) & 64'(DistMask));
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [DistW-1:0] got,
                                 input logic [DistW-1:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest pending distance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_dist.size() == 0) begin
        report_mismatch("unexpected result", distance_mm_o, '0);
      end else begin
        if (distance_mm_o !== pending_dist[0])
          report_mismatch("distance_mm", distance_mm_o, pending_dist[0]);
        void'(pending_dist.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  // Present one request and hold it until taken; queue its expected distance.
  // The value typed in the row overrides the predictor only when asked.
  task automatic send_pair(input point_pair_t p, input bit typed,
                           input logic [DistW-1:0] typed_dist);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    first_lat_i  <= p.lat1;
    first_lon_i  <= p.lon1;
    second_lat_i <= p.lat2;
    second_lon_i <= p.lon2;
    do @(posedge clk_i); while (busy);
    pending_dist.push_back(typed ? typed_dist : great_circle_mm(p, radius_mm));
  endtask

  // Drain outstanding requests, then write the radius while the pipe is empty.
  task automatic write_radius(input logic [RadiusW-1:0] r);
    start <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    radius_mm = r;
  endtask

  function automatic point_pair_t random_pair();
    point_pair_t p;
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      // raw bit patterns, far outside the stated ranges too
      p.lat1 = LatW'($urandom);
      p.lon1 = LonW'($urandom);
      p.lat2 = LatW'($urandom);
      p.lon2 = LonW'($urandom);
    end else if (sel < 25) begin
      // nearby points: small differences stress sin of tiny angles
      p.lat1 = LatW'(int'($urandom_range(180000000)) - 90000000);
      p.lon1 = LonW'(int'($urandom_range(360000000)) - 180000000);
      p.lat2 = (p.lat1 > 89000000) ? p.lat1 - LatW'($urandom_range(1000))
                                   : p.lat1 + LatW'($urandom_range(1000));
      p.lon2 = p.lon1 + LonW'(int'($urandom_range(2000)) - 1000);
    end else begin
      p.lat1 = LatW'(int'($urandom_range(180000000)) - 90000000);
      p.lon1 = LonW'(int'($urandom_range(360000000)) - 180000000);
      p.lat2 = LatW'(int'($urandom_range(180000000)) - 90000000);
      p.lon2 = LonW'(int'($urandom_range(360000000)) - 180000000);
    end
    return p;
  endfunction

  function automatic point_pair_t mk_pair(input int a, input int b, input int c, input int d);
    point_pair_t p;
    p.lat1 = LatW'(a);
    p.lon1 = LonW'(b);
    p.lat2 = LatW'(c);
    p.lon2 = LonW'(d);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  pair_row_t directed_rows [$];
  int        phase_idle [4] = '{0, 68, 0, 15};

  initial begin
    logic [RadiusW-1:0] radii [5];
    pair_row_t row;
    int mn;
    int mx;

    rst_ni       = 1'b0;
    start        = 1'b0;
    first_lat_i  = '0;
    first_lon_i  = '0;
    second_lat_i = '0;
    second_lon_i = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    mismatches   = 0;
    cycles       = 0;
    idle_pct     = 0;
    radius_mm    = RadiusReset;
    build_angle_tables();

    // Directed pairs; under a zero radius every distance is zero.
    mn = -(1 << 27);
    mx = (1 << 27) - 1;
    row.zero_radius_dist = '0;
    row.pair = mk_pair(0, 0, 0, 0);                          directed_rows.push_back(row);
    row.pair = mk_pair(45000000, 10000000, 45000000, 10000000); directed_rows.push_back(row);
    row.pair = mk_pair(90000000, 0, -90000000, 0);           directed_rows.push_back(row);
    row.pair = mk_pair(0, 0, 0, 180000000);                  directed_rows.push_back(row);
    row.pair = mk_pair(0, -180000000, 0, 180000000);         directed_rows.push_back(row);
    row.pair = mk_pair(0, 180000000, 0, -180000000);         directed_rows.push_back(row);
    row.pair = mk_pair(90000000, 0, 90000000, 123456789);    directed_rows.push_back(row);
    row.pair = mk_pair(-90000000, -180000000, -90000000, 180000000); directed_rows.push_back(row);
    row.pair = mk_pair(45000000, 10000000, -45000000, -170000000);   directed_rows.push_back(row);
    row.pair = mk_pair(1, 0, 0, 0);                          directed_rows.push_back(row);
    row.pair = mk_pair(0, 0, 0, 1);                          directed_rows.push_back(row);
    row.pair = mk_pair(90000000, 180000000, -90000000, -180000000);  directed_rows.push_back(row);
    row.pair = mk_pair(mn, -(1 << 28), mx, (1 << 28) - 1);   directed_rows.push_back(row);
    row.pair = mk_pair(mx, (1 << 28) - 1, mn, -(1 << 28));   directed_rows.push_back(row);
    row.pair = mk_pair(mx, 0, mx, 0);                        directed_rows.push_back(row);
    row.pair = mk_pair(-1, -1, 1, 1);                        directed_rows.push_back(row);
    row.pair = mk_pair(51477500, -1000, 40689200, -74044500); directed_rows.push_back(row);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table at the reset radius, predicted.
    foreach (directed_rows[i]) send_pair(directed_rows[i].pair, 1'b0, '0);

    // Walk it again with a zero radius; expected distances are typed in.
    write_radius('0);
    foreach (directed_rows[i])
      send_pair(directed_rows[i].pair, 1'b1, directed_rows[i].zero_radius_dist);

    // Random phases: each one a radius and an idle pattern.
    radii[0] = RadiusW'(64'd8000000000);
    radii[1] = RadiusReset;
    radii[2] = '1;
    radii[3] = {1'b0, $urandom};
    radii[4] = RadiusW'(1);
    for (int ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      idle_pct = phase_idle[ph % 4];
      for (int n = 0; n < RandItems / 5; n++) send_pair(random_pair(), 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/hgcd_pkg.sv
rtl/core/haversine_great_circle_distance.sv
dv/tb_top.sv
